// File: sv/clr_pkg.sv
`timescale 1ns / 1ps

package clr_pkg;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT   = 3'd0,
      MODE_REMOVE   = 3'd1,
      MODE_ROT_FWD  = 3'd2,
      MODE_ROT_BACK = 3'd3,
      MODE_CLEAR    = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LINK,
      S_FETCH,
      S_LOAD,
      S_RESULT
   } state_type;

   typedef enum logic [2:0] {
      EX_NONE,
      EX_INS_FIRST,
      EX_INSERT,
      EX_REM_LAST,
      EX_REMOVE,
      EX_ROT_FWD,
      EX_ROT_BACK,
      EX_CLEAR
   } exec_type;

   typedef struct packed {
      logic       take_req;
      exec_type   exec;
      logic       set_status;
      status_type status;
      logic       link;
      logic       load;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     held_zero;
      logic     held_one;
      logic     full;
   } sts_type;

endpackage

// File: sv/clr_ifs.sv
`timescale 1ns / 1ps

interface clr_req_if;
   logic                       valid;
   logic                       ready;
   logic [clr_pkg::MODE_W-1:0]  mode;
   logic [clr_pkg::VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

interface clr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [clr_pkg::VALUE_W-1:0]  current_value;
   logic [clr_pkg::COUNT_W-1:0]  entry_count;
   logic                         is_empty;
   logic [clr_pkg::STATUS_W-1:0] status;

   modport source (output valid, output current_value, output entry_count,
                   output is_empty, output status, input ready);
   modport sink (input valid, input current_value, input entry_count,
                 input is_empty, input status, output ready);
endinterface

// File: sv/clr_ctrl.sv
`timescale 1ns / 1ps

module clr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  clr_pkg::sts_type sts,
   output clr_pkg::cmd_type cmd
);

   clr_pkg::state_type  state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   // decision for the operation in flight
   clr_pkg::exec_type   exec_sel;
   clr_pkg::status_type status_sel;
   clr_pkg::state_type  exec_next;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == clr_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      exec_sel   = clr_pkg::EX_NONE;
      status_sel = clr_pkg::ST_DONE;
      exec_next  = clr_pkg::S_RESULT;
      case (sts.mode)
         clr_pkg::MODE_INSERT: begin
            if (sts.full) begin
               status_sel = clr_pkg::ST_FULL;
            end else if (sts.held_zero) begin
               exec_sel = clr_pkg::EX_INS_FIRST;
            end else begin
               exec_sel  = clr_pkg::EX_INSERT;
               exec_next = clr_pkg::S_LINK;
            end
         end
         clr_pkg::MODE_REMOVE: begin
            if (sts.held_zero) begin
               status_sel = clr_pkg::ST_EMPTY;
            end else if (sts.held_one) begin
               exec_sel = clr_pkg::EX_REM_LAST;
            end else begin
               exec_sel  = clr_pkg::EX_REMOVE;
               exec_next = clr_pkg::S_FETCH;
            end
         end
         clr_pkg::MODE_ROT_FWD, clr_pkg::MODE_ROT_BACK: begin
            if (sts.held_zero) begin
               status_sel = clr_pkg::ST_EMPTY;
            end else begin
               exec_sel  = (sts.mode == clr_pkg::MODE_ROT_FWD) ? clr_pkg::EX_ROT_FWD
                                                                : clr_pkg::EX_ROT_BACK;
               exec_next = clr_pkg::S_FETCH;
            end
         end
         clr_pkg::MODE_CLEAR: begin
            exec_sel = clr_pkg::EX_CLEAR;
         end
         default: begin
            exec_sel = clr_pkg::EX_NONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clr_pkg::S_IDLE: begin
            if (req_valid) state_in = clr_pkg::S_EXEC;
         end
         clr_pkg::S_EXEC:   state_in = exec_next;
         clr_pkg::S_LINK:   state_in = clr_pkg::S_RESULT;
         clr_pkg::S_FETCH:  state_in = clr_pkg::S_LOAD;
         clr_pkg::S_LOAD:   state_in = clr_pkg::S_RESULT;
         clr_pkg::S_RESULT: begin
            if (rsp_free) state_in = clr_pkg::S_IDLE;
         end
         default:           state_in = clr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         clr_pkg::S_IDLE: begin
            cmd.take_req = req_valid;
         end
         clr_pkg::S_EXEC: begin
            cmd.exec       = exec_sel;
            cmd.set_status = 1'b1;
            cmd.status     = status_sel;
         end
         clr_pkg::S_LINK: begin
            cmd.link = 1'b1;
         end
         clr_pkg::S_LOAD: begin
            cmd.load = 1'b1;
         end
         clr_pkg::S_RESULT: begin
            cmd.rsp_load = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/clr_dpath.sv
`timescale 1ns / 1ps

module clr_dpath #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  clr_pkg::cmd_type              cmd,
   output clr_pkg::sts_type              sts,
   input  logic [clr_pkg::MODE_W-1:0]    req_mode,
   input  logic [clr_pkg::VALUE_W-1:0]   req_value,
   output logic [clr_pkg::VALUE_W-1:0]   rsp_current_value,
   output logic [clr_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                          rsp_is_empty,
   output logic [clr_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int OUT_W  = clr_pkg::VALUE_W;
   localparam int OCNT_W = clr_pkg::COUNT_W;

   // slot stores and the stack of freed slots
   logic [VALUE_BITS-1:0] value_mem [CAPACITY];
   logic [SLOT_W-1:0]     next_mem  [CAPACITY];
   logic [SLOT_W-1:0]     prev_mem  [CAPACITY];
   logic [SLOT_W-1:0]     free_mem  [CAPACITY];

   logic [VALUE_BITS-1:0] value_rd_ff;
   logic [SLOT_W-1:0]     next_rd_ff, prev_rd_ff, free_rd_ff;

   logic [clr_pkg::MODE_W-1:0] mode_ff;
   logic [VALUE_BITS-1:0]      value_ff;
   clr_pkg::status_type        status_ff;

   logic [CNT_W-1:0]  held_ff, held_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in;
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [SLOT_W-1:0] cursor_ff, cursor_in;

   logic [VALUE_BITS-1:0] cur_value_ff, cur_value_in;
   logic [SLOT_W-1:0]     cur_next_ff, cur_next_in;
   logic [SLOT_W-1:0]     cur_prev_ff, cur_prev_in;

   logic [OUT_W-1:0]  rsp_value_ff;
   logic [OCNT_W-1:0] rsp_count_ff;
   logic              rsp_empty_ff;
   logic [clr_pkg::STATUS_W-1:0] rsp_status_ff;

   logic [SLOT_W-1:0] new_slot, top_addr;

   logic                  value_we;
   logic [SLOT_W-1:0]     value_wa;
   logic [VALUE_BITS-1:0] value_wd;
   logic                  next_we, prev_we, free_we;
   logic [SLOT_W-1:0]     next_wa, next_wd, prev_wa, prev_wd, free_wa, free_wd;

   // fresh slots are those never handed out since the last clear
   assign top_addr = SLOT_W'(depth_ff - CNT_W'(1));
   assign new_slot = (depth_ff != '0) ? free_rd_ff : fresh_ff[SLOT_W-1:0];

   assign sts.mode      = clr_pkg::mode_type'(mode_ff);
   assign sts.held_zero = (held_ff == '0);
   assign sts.held_one  = (held_ff == CNT_W'(1));
   assign sts.full      = (held_ff == CNT_W'(CAPACITY));

   always_comb begin
      value_we = 1'b0;
      value_wa = new_slot;
      value_wd = value_ff;
      next_we  = 1'b0;
      next_wa  = '0;
      next_wd  = '0;
      prev_we  = 1'b0;
      prev_wa  = '0;
      prev_wd  = '0;
      free_we  = 1'b0;
      free_wa  = depth_ff[SLOT_W-1:0];
      free_wd  = cursor_ff;
      case (cmd.exec)
         clr_pkg::EX_INS_FIRST: begin
            value_we = 1'b1;
            next_we  = 1'b1;
            next_wa  = new_slot;
            next_wd  = new_slot;
            prev_we  = 1'b1;
            prev_wa  = new_slot;
            prev_wd  = new_slot;
         end
         clr_pkg::EX_INSERT: begin
            value_we = 1'b1;
            next_we  = 1'b1;
            next_wa  = new_slot;
            next_wd  = cursor_ff;
            prev_we  = 1'b1;
            prev_wa  = new_slot;
            prev_wd  = cur_prev_ff;
         end
         clr_pkg::EX_REMOVE: begin
            next_we = 1'b1;
            next_wa = cur_prev_ff;
            next_wd = cur_next_ff;
            prev_we = 1'b1;
            prev_wa = cur_next_ff;
            prev_wd = cur_prev_ff;
            free_we = 1'b1;
         end
         clr_pkg::EX_REM_LAST: begin
            free_we = 1'b1;
         end
         default: begin
            value_we = 1'b0;
         end
      endcase
      // splice the new entry between its neighbors
      if (cmd.link) begin
         next_we = 1'b1;
         next_wa = cur_prev_ff;
         next_wd = cursor_ff;
         prev_we = 1'b1;
         prev_wa = cur_next_ff;
         prev_wd = cursor_ff;
      end
   end

   always_comb begin
      held_in      = held_ff;
      fresh_in     = fresh_ff;
      depth_in     = depth_ff;
      cursor_in    = cursor_ff;
      cur_value_in = cur_value_ff;
      cur_next_in  = cur_next_ff;
      cur_prev_in  = cur_prev_ff;
      case (cmd.exec)
         clr_pkg::EX_INS_FIRST, clr_pkg::EX_INSERT: begin
            held_in = held_ff + CNT_W'(1);
            if (depth_ff != '0) begin
               depth_in = depth_ff - CNT_W'(1);
            end else begin
               fresh_in = fresh_ff + CNT_W'(1);
            end
            cursor_in    = new_slot;
            cur_value_in = value_ff;
            if (cmd.exec == clr_pkg::EX_INS_FIRST) begin
               cur_next_in = new_slot;
               cur_prev_in = new_slot;
            end else begin
               cur_next_in = cursor_ff;
            end
         end
         clr_pkg::EX_REMOVE: begin
            held_in   = held_ff - CNT_W'(1);
            depth_in  = depth_ff + CNT_W'(1);
            cursor_in = cur_next_ff;
         end
         clr_pkg::EX_REM_LAST: begin
            held_in   = held_ff - CNT_W'(1);
            depth_in  = depth_ff + CNT_W'(1);
            cursor_in = '0;
         end
         clr_pkg::EX_ROT_FWD: begin
            cursor_in = cur_next_ff;
         end
         clr_pkg::EX_ROT_BACK: begin
            cursor_in = cur_prev_ff;
         end
         clr_pkg::EX_CLEAR: begin
            held_in   = '0;
            fresh_in  = '0;
            depth_in  = '0;
            cursor_in = '0;
         end
         default: begin
            held_in = held_ff;
         end
      endcase
      // refresh the cursor cache from the stores
      if (cmd.load) begin
         cur_value_in = value_rd_ff;
         cur_next_in  = next_rd_ff;
         cur_prev_in  = prev_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (value_we) value_mem[value_wa] <= value_wd;
      if (next_we)  next_mem[next_wa]   <= next_wd;
      if (prev_we)  prev_mem[prev_wa]   <= prev_wd;
      if (free_we)  free_mem[free_wa]   <= free_wd;
      value_rd_ff <= value_mem[cursor_ff];
      next_rd_ff  <= next_mem[cursor_ff];
      prev_rd_ff  <= prev_mem[cursor_ff];
      free_rd_ff  <= free_mem[top_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         fresh_ff  <= '0;
         depth_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         held_ff   <= held_in;
         fresh_ff  <= fresh_in;
         depth_ff  <= depth_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_value_ff <= cur_value_in;
      cur_next_ff  <= cur_next_in;
      cur_prev_ff  <= cur_prev_in;
      if (cmd.take_req) begin
         mode_ff  <= req_mode;
         value_ff <= VALUE_BITS'(req_value);
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= (held_ff != '0) ? OUT_W'(cur_value_ff) : '0;
         rsp_count_ff  <= OCNT_W'(held_ff);
         rsp_empty_ff  <= (held_ff == '0);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_current_value = rsp_value_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// File: sv/circular_list_with_cursor.sv
// Sequence: each word passes S_EXEC, then S_RESULT. Insert into an empty list,
//   remove of the last entry, clear and refused words go from S_EXEC to S_RESULT;
//   insert into a non-empty list adds S_LINK (second link write), and remove and
//   rotate add S_FETCH and S_LOAD for the registered read of the link and value
//   stores at the new cursor. One word at a time; results wait in an output register.
// Reset: synchronous; list empty, cursor at slot zero, stores keep their contents.
`timescale 1ns / 1ps

module circular_list_with_cursor #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   clr_req_if.sink   req_ch,
   clr_rsp_if.source rsp_ch
);

   clr_pkg::cmd_type cmd;
   clr_pkg::sts_type sts;

   clr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   clr_dpath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_ch.mode),
      .req_value         (req_ch.value),
      .rsp_current_value (rsp_ch.current_value),
      .rsp_entry_count   (rsp_ch.entry_count),
      .rsp_is_empty      (rsp_ch.is_empty),
      .rsp_status        (rsp_ch.status)
   );

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("word accepted while another is in flight");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec == clr_pkg::EX_INSERT || cmd.exec == clr_pkg::EX_INS_FIRST)
      |-> !sts.full)
      else $error("insert issued on a full list");

   a_need_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec == clr_pkg::EX_REMOVE || cmd.exec == clr_pkg::EX_REM_LAST ||
       cmd.exec == clr_pkg::EX_ROT_FWD || cmd.exec == clr_pkg::EX_ROT_BACK)
      |-> !sts.held_zero)
      else $error("remove or rotate issued on an empty list");

   a_rsp_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_ch.valid)
      else $error("loaded result not presented");

endmodule

// File: sim/cursor_list_monitor.sv
`timescale 1ns / 1ps

module cursor_list_monitor (
   input  logic clock,
   input  logic reset,
   clr_req_if   req_mon,
   clr_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding
);

   localparam int SLOTS  = 64;
   localparam int SLOT_W = 6;

   typedef struct packed {
      logic [clr_pkg::VALUE_W-1:0] cur;
      logic [clr_pkg::COUNT_W-1:0] count;
      logic                        empty;
      clr_pkg::status_type         st;
   } list_view_type;

   logic [clr_pkg::VALUE_W-1:0] slot_val  [SLOTS];
   logic [SLOT_W-1:0]           fwd_link  [SLOTS];
   logic [SLOT_W-1:0]           back_link [SLOTS];
   logic [SLOTS-1:0]            slot_busy;
   logic [SLOT_W-1:0]           cursor;
   logic [clr_pkg::COUNT_W-1:0] held;

   list_view_type view_q[$];
   int            errors = 0;

   task automatic apply_op(input logic [clr_pkg::MODE_W-1:0] op,
                           input logic [clr_pkg::VALUE_W-1:0] data,
                           output list_view_type view);
      logic [SLOT_W-1:0]   free_slot;
      logic [SLOT_W-1:0]   p;
      logic [SLOT_W-1:0]   n;
      clr_pkg::status_type st;
      st = clr_pkg::ST_DONE;
      case (op)
         clr_pkg::MODE_INSERT: begin
            if (held == clr_pkg::COUNT_W'(SLOTS)) begin
               st = clr_pkg::ST_FULL;
            end else begin
               free_slot = '0;
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!slot_busy[i]) free_slot = SLOT_W'(i);
               slot_val[free_slot]  = data;
               slot_busy[free_slot] = 1'b1;
               if (held == '0) begin
                  fwd_link[free_slot]  = free_slot;
                  back_link[free_slot] = free_slot;
               end else begin
                  // splice in just ahead of the cursor
                  p                    = back_link[cursor];
                  back_link[free_slot] = p;
                  fwd_link[free_slot]  = cursor;
                  fwd_link[p]          = free_slot;
                  back_link[cursor]    = free_slot;
               end
               cursor = free_slot;
               held   = held + clr_pkg::COUNT_W'(1);
            end
         end
         clr_pkg::MODE_REMOVE: begin
            if (held == '0) begin
               st = clr_pkg::ST_EMPTY;
            end else begin
               slot_busy[cursor] = 1'b0;
               if (held == clr_pkg::COUNT_W'(1)) begin
                  cursor = '0;
               end else begin
                  p            = back_link[cursor];
                  n            = fwd_link[cursor];
                  fwd_link[p]  = n;
                  back_link[n] = p;
                  cursor       = n;
               end
               held = held - clr_pkg::COUNT_W'(1);
            end
         end
         clr_pkg::MODE_ROT_FWD, clr_pkg::MODE_ROT_BACK: begin
            if (held == '0)
               st = clr_pkg::ST_EMPTY;
            else
               cursor = (op == clr_pkg::MODE_ROT_FWD) ? fwd_link[cursor] : back_link[cursor];
         end
         clr_pkg::MODE_CLEAR: begin
            slot_busy = '0;
            held      = '0;
            cursor    = '0;
         end
         default: ;
      endcase
      view.cur   = (held != '0) ? slot_val[cursor] : '0;
      view.count = held;
      view.empty = (held == '0);
      view.st    = st;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      list_view_type want;
      list_view_type got;
      if (reset) begin
         slot_busy = '0;
         cursor    = '0;
         held      = '0;
         view_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            apply_op(req_mon.mode, req_mon.value, want);
            view_q.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.cur   = rsp_mon.current_value;
            got.count = rsp_mon.entry_count;
            got.empty = rsp_mon.is_empty;
            got.st    = clr_pkg::status_type'(rsp_mon.status);
            if (view_q.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got value %0h count %0d",
                        $time, got.cur, got.count);
               errors++;
            end else begin
               want = view_q.pop_front();
               check_field("current_value", 64'(want.cur), 64'(got.cur));
               check_field("entry_count", 64'(want.count), 64'(got.count));
               check_field("is_empty", 64'(want.empty), 64'(got.empty));
               check_field("status", 64'(want.st), 64'(got.st));
            end
         end
      end
      outstanding <= view_q.size();
      fail_count  <= errors;
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam logic [clr_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
   localparam logic [clr_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [clr_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   localparam int BURST_GROW   = 0;
   localparam int BURST_SHRINK = 1;
   localparam int BURST_CHURN  = 2;

   localparam int WORD_TARGET  = 1250;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 200;
   localparam int STUCK_LIMIT  = 2000;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   words_sent = 0;
   bit   send_quiet = 0;
   int   stuck;

   clr_req_if req_ch ();
   clr_rsp_if rsp_ch ();

   circular_list_with_cursor DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cursor_list_monitor list_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_word(input logic [clr_pkg::MODE_W-1:0] op,
                            input logic [clr_pkg::VALUE_W-1:0] data);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= op;
      req_ch.value <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   // hold the input until every result word is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [clr_pkg::VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll == 2) return clr_pkg::VALUE_W'($urandom_range(0, 15));
      return $urandom;
   endfunction

   function automatic logic [clr_pkg::MODE_W-1:0] pick_op(input int kind);
      int roll;
      roll = $urandom_range(0, 99);
      case (kind)
         BURST_GROW: begin
            if (roll < 70) return clr_pkg::MODE_INSERT;
            if (roll < 80) return clr_pkg::MODE_ROT_FWD;
            if (roll < 88) return clr_pkg::MODE_ROT_BACK;
            if (roll < 98) return clr_pkg::MODE_REMOVE;
         end
         BURST_SHRINK: begin
            if (roll < 15) return clr_pkg::MODE_INSERT;
            if (roll < 65) return clr_pkg::MODE_REMOVE;
            if (roll < 80) return clr_pkg::MODE_ROT_FWD;
            if (roll < 97) return clr_pkg::MODE_ROT_BACK;
         end
         default: begin
            if (roll < 35) return clr_pkg::MODE_INSERT;
            if (roll < 60) return clr_pkg::MODE_REMOVE;
            if (roll < 75) return clr_pkg::MODE_ROT_FWD;
            if (roll < 90) return clr_pkg::MODE_ROT_BACK;
            if (roll < 95) return clr_pkg::MODE_CLEAR;
         end
      endcase
      return clr_pkg::MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
   endfunction

   // stimulus
   initial begin
      int kind;
      int burst_len;
      int bursts;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.mode  <= clr_pkg::MODE_INSERT;
      req_ch.value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      send_word(clr_pkg::MODE_CLEAR, 32'h1234_5678);
      send_word(clr_pkg::MODE_REMOVE, '0);
      send_word(clr_pkg::MODE_ROT_FWD, '1);
      send_word(clr_pkg::MODE_ROT_BACK, '0);
      send_word(MODE_SPARE_5, '1);
      send_word(MODE_SPARE_6, '0);
      send_word(MODE_SPARE_7, '1);
      // single entry: rotate stays put
      send_word(clr_pkg::MODE_INSERT, '0);
      send_word(clr_pkg::MODE_ROT_FWD, '0);
      send_word(clr_pkg::MODE_ROT_BACK, '0);
      send_word(clr_pkg::MODE_INSERT, '1);
      send_word(clr_pkg::MODE_INSERT, 32'h5555_5555);
      send_word(clr_pkg::MODE_INSERT, 32'hAAAA_AAAA);
      send_word(clr_pkg::MODE_ROT_FWD, '0);
      send_word(clr_pkg::MODE_ROT_BACK, '0);
      send_word(clr_pkg::MODE_ROT_BACK, '0);
      send_word(clr_pkg::MODE_REMOVE, '0);
      send_word(MODE_SPARE_7, '0);
      send_word(clr_pkg::MODE_CLEAR, '0);
      send_word(clr_pkg::MODE_INSERT, 32'h8000_0001);
      send_word(clr_pkg::MODE_REMOVE, '0);
      send_word(clr_pkg::MODE_CLEAR, '0);

      // fill past capacity so the full case shows up, then let it drain
      repeat (70) send_word(clr_pkg::MODE_INSERT, pick_value());
      drain_results();

      bursts = 0;
      while (words_sent < WORD_TARGET) begin
         kind       = $urandom_range(BURST_GROW, BURST_CHURN);
         burst_len  = $urandom_range(20, 100);
         send_quiet = ($urandom_range(0, 3) == 0);
         repeat (burst_len) send_word(pick_op(kind), pick_value());
         bursts++;
         if (bursts % 4 == 0) drain_results();
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("circular_list_with_cursor test passed");
      else
         $display("circular_list_with_cursor test failed");
      $finish;
   end

   // result side
   initial begin
      int stall;
      int taken;
      bit rsp_quiet;
      taken     = 0;
      rsp_quiet = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         taken++;
         if (taken % 64 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
         // back up the block while the sender keeps offering words
         if (taken == HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("circular_list_with_cursor test failed");
      $finish;
   end

endmodule
